FILE: rtl/core/sed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_pkg: shared definitions for the STX/ETX escape deframer
// Framing byte codes, field widths and the result record that travels from
// the frame decoder to the output buffer.
// ----------------------------------------------------------------------------
package sed_pkg;

   // Field widths fixed by the link format.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Framing codes on the link.
   localparam logic [BYTE_W-1:0] STX_CODE = 8'h02;
   localparam logic [BYTE_W-1:0] ETX_CODE = 8'h03;
   localparam logic [BYTE_W-1:0] ESC_CODE = 8'h0F;
   localparam logic [BYTE_W-1:0] ESC_FLIP = 8'h40;

   // Register map.
   localparam logic REG_MAX_FRAME_LENGTH = 1'b0;
   localparam logic [LEN_W-1:0] MAX_FRAME_LENGTH_RESET = 11'd64;

   // Default ceiling on the programmed frame length.
   localparam int MAX_LEN_LIMIT_DEFAULT = 1024;

   // One decoded result.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              data_valid;
      logic              frame_end;
      logic [LEN_W-1:0]  frame_length;
      logic              frame_truncated;
   } result_type;

   // Result plus its strobe, from the decoder to the output buffer.
   typedef struct packed {
      logic       valid;
      result_type result;
   } result_push_type;

endpackage

FILE: rtl/core/sed_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_decoder: frame state and byte decode
// Holds the hunt/in-frame state, the pending escape and the payload count,
// and turns each accepted link byte into at most one result.
// ----------------------------------------------------------------------------
module sed_decoder #(
   parameter int MAX_LEN_LIMIT = sed_pkg::MAX_LEN_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [sed_pkg::BYTE_W-1:0]    rx_byte,
   input  logic [sed_pkg::LEN_W-1:0]     max_frame_length,
   output sed_pkg::result_push_type      push
);

   // Width that holds both the programmed length and the ceiling.
   localparam int CEIL_W = $clog2(MAX_LEN_LIMIT + 1);
   localparam int LIM_W  = (CEIL_W > sed_pkg::LEN_W) ? CEIL_W : sed_pkg::LEN_W;
   localparam logic [LIM_W-1:0] CEILING = LIM_W'(MAX_LEN_LIMIT);

   logic                       in_frame_ff, in_frame_in;
   logic                       escape_ff, escape_in;
   logic [sed_pkg::LEN_W-1:0]  count_ff, count_in;
   logic [LIM_W-1:0]           limit;
   logic [LIM_W-1:0]           cfg_ext;
   logic [sed_pkg::LEN_W-1:0]  count_inc;
   logic [sed_pkg::BYTE_W-1:0] payload;

   // Effective limit: zero acts as one, anything above the ceiling is clipped.
   always_comb begin
      cfg_ext = LIM_W'(max_frame_length);
      if (cfg_ext == '0) begin
         limit = LIM_W'(1);
      end else if (cfg_ext > CEILING) begin
         limit = CEILING;
      end else begin
         limit = cfg_ext;
      end
   end

   assign count_inc = count_ff + sed_pkg::LEN_W'(1);
   assign payload   = escape_ff ? (rx_byte ^ sed_pkg::ESC_FLIP) : rx_byte;

   // Next state and result for the byte at hand.
   always_comb begin
      in_frame_in = in_frame_ff;
      escape_in   = escape_ff;
      count_in    = count_ff;
      push        = '0;
      if (accept) begin
         if (!in_frame_ff) begin
            // Hunting: only STX opens a frame.
            if (rx_byte == sed_pkg::STX_CODE) begin
               in_frame_in = 1'b1;
               escape_in   = 1'b0;
               count_in    = '0;
            end
         end else if (rx_byte == sed_pkg::ETX_CODE) begin
            // ETX closes the frame even after an escape; empty frames vanish.
            in_frame_in = 1'b0;
            escape_in   = 1'b0;
            count_in    = '0;
            if (count_ff != '0) begin
               push.valid               = 1'b1;
               push.result.frame_end    = 1'b1;
               push.result.frame_length = count_ff;
            end
         end else if (!escape_ff && rx_byte == sed_pkg::ESC_CODE) begin
            escape_in = 1'b1;
         end else begin
            // Payload byte, closing the frame as truncated at the limit.
            push.valid                  = 1'b1;
            push.result.data_byte       = payload;
            push.result.data_valid      = 1'b1;
            push.result.frame_length    = count_inc;
            escape_in                   = 1'b0;
            if (LIM_W'(count_inc) >= limit) begin
               push.result.frame_end       = 1'b1;
               push.result.frame_truncated = 1'b1;
               in_frame_in                 = 1'b0;
               count_in                    = '0;
            end else begin
               count_in = count_inc;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         escape_ff   <= 1'b0;
         count_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         escape_ff   <= escape_in;
         count_ff    <= count_in;
      end
   end

endmodule

FILE: rtl/core/sed_out_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sed_out_buffer: result register with skid stage
// Presents results on the response channel and absorbs one extra result
// while the receiver stalls, so the request side never waits on rsp_stall
// combinationally.
// ----------------------------------------------------------------------------
module sed_out_buffer (
   input  logic                     clock,
   input  logic                     reset,
   input  sed_pkg::result_push_type push,
   output logic                     full,
   output logic                     out_valid,
   input  logic                     out_stall,
   output sed_pkg::result_type      out_result
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   sed_pkg::result_type main_ff, main_in;
   sed_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop = main_valid_ff && !out_stall;

   // Move results between the skid stage and the output register.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff && !pop) begin
         if (push.valid) begin
            skid_in       = push.result;
            skid_valid_in = 1'b1;
         end
      end else begin
         main_valid_in = push.valid;
         main_in       = push.result;
      end
   end

   // Control bits reset; payload needs none.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full       = skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_result = main_ff;

endmodule

FILE: rtl/core/stx_etx_escape_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_escape_deframer: STX/ETX byte-stuffing receive deframer
// Hunts for STX, unescapes the payload, counts it, and closes each frame on
// ETX or on the programmed length limit.
//
//   Channel  Direction  Ports                      Carries
//   req      in         req_valid / req_stall      one raw link byte
//   rsp      out        rsp_valid / rsp_stall      one payload byte or frame end
//   csr      in/out     csr_psel ... csr_pready    max_frame_length at 0x0
//
// A request is taken in every cycle while req_stall is low; its result, if
// any, is decoded combinationally from the byte and the decoder state and
// registered in the output buffer before it appears on rsp. A two-entry
// output buffer lets one result wait under rsp_stall; req_stall rises only
// when both entries are full. Reset is synchronous and returns the block to
// hunting for STX with max_frame_length at 64.
// ----------------------------------------------------------------------------
module stx_etx_escape_deframer #(
   parameter int MAX_LEN_LIMIT = sed_pkg::MAX_LEN_LIMIT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sed_pkg::BYTE_W-1:0]        req_rx_byte,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sed_pkg::BYTE_W-1:0]        rsp_data_byte,
   output logic                              rsp_data_valid,
   output logic                              rsp_frame_end,
   output logic [sed_pkg::LEN_W-1:0]         rsp_frame_length,
   output logic                              rsp_frame_truncated,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sed_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sed_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sed_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic                         accept;
   logic                         buffer_full;
   logic [sed_pkg::LEN_W-1:0]    max_len_ff, max_len_in;
   logic                         reg_sel;
   sed_pkg::result_push_type     push;
   sed_pkg::result_type          out_result;

   // Register decode: word index sits above the byte offset.
   assign reg_sel    = (csr_paddr[sed_pkg::CSR_ADDR_W-1] == sed_pkg::REG_MAX_FRAME_LENGTH);
   assign csr_pready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         max_len_in = csr_pwdata[sed_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= sed_pkg::MAX_FRAME_LENGTH_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign csr_prdata = reg_sel ? sed_pkg::CSR_DATA_W'(max_len_ff) : '0;

   // Request handshake.
   assign req_stall = buffer_full;
   assign accept    = req_valid && !buffer_full;

   sed_decoder #(
      .MAX_LEN_LIMIT (MAX_LEN_LIMIT)
   ) u_decoder (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .rx_byte          (req_rx_byte),
      .max_frame_length (max_len_ff),
      .push             (push)
   );

   sed_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (buffer_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (out_result)
   );

   assign rsp_data_byte       = out_result.data_byte;
   assign rsp_data_valid      = out_result.data_valid;
   assign rsp_frame_end       = out_result.frame_end;
   assign rsp_frame_length    = out_result.frame_length;
   assign rsp_frame_truncated = out_result.frame_truncated;

endmodule
